// ----- design/spq_pkg.sv -----
// Package for the sorted priority queue: depth, widths, status codes and
// the cell control struct. No dependencies.
package spq_pkg;

  // Number of cells in the chain
  localparam int unsigned DEPTH = 16;
  // Width of the live-entry count (holds 0..DEPTH)
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  // Width of the capacity register and of the entry count result
  localparam int unsigned CapW  = 5;
  // Width used when comparing count against capacity
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;

  localparam int unsigned ValW  = 32;
  localparam int unsigned PrioW = 16;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// One cell of the sorted chain: holds one entry, compares it against the
// incoming priority and takes data from a neighbour. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  spq_ctrl_t               ctrl_i,
  input  logic                    occupied_i,
  input  logic signed [ValW-1:0]  new_value_i,
  input  logic signed [PrioW-1:0] new_prio_i,
  input  logic                    left_lt_i,
  input  logic signed [ValW-1:0]  left_value_i,
  input  logic signed [PrioW-1:0] left_prio_i,
  input  logic signed [ValW-1:0]  right_value_i,
  input  logic signed [PrioW-1:0] right_prio_i,
  output logic                    lt_o,
  output logic signed [ValW-1:0]  value_o,
  output logic signed [PrioW-1:0] prio_o
);

  logic signed [ValW-1:0]  value_q, value_d;
  logic signed [PrioW-1:0] prio_q, prio_d;

  // New entry goes ahead of this slot when the slot is free or holds
  // a strictly lower priority
  assign lt_o = !occupied_i || (prio_q < new_prio_i);

  // Choose the next contents: insert, shift back, shift forward or hold
  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.enq && lt_o) begin
      if (left_lt_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (ctrl_i.deq) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  // Entry payload needs no reset: slots are read only below the count
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: count, capacity register, result
// register and the chain of spq_cell instances. Depends on spq_pkg, spq_cell.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  in       | in        | in_valid_i/in_stall_o  | action_i, item_value_i, item_priority_i
//  out      | out       | out_valid_o/out_stall_i| status_o, out_value_o, entry_count_o
//  cfg      | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (capacity)
//
// For each request all cells compare and shift at once, and the result is
// registered for the next cycle. A request is taken when no result is held
// or the held result leaves in the same cycle.
// Reset empties the queue and sets capacity to 16; no clearing pass is run.
// A stalled result holds the input side stalled.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic signed [ValW-1:0]  item_value_i,
  input  logic signed [PrioW-1:0] item_priority_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [ValW-1:0]  out_value_o,
  output logic [CapW-1:0]         entry_count_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CapW-1:0]         cfg_data_i
);

  logic [CntW-1:0]        count_q, count_d;
  logic [CapW-1:0]        cap_q;
  logic [CmpW-1:0]        cap_eff;
  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic signed [ValW-1:0] value_q, value_d;
  logic [CntW-1:0]        res_count_q;
  logic                   accept;
  logic                   full;
  logic                   empty;
  spq_ctrl_t              ctrl;

  logic                    lt     [DEPTH];
  logic signed [ValW-1:0]  cval   [DEPTH];
  logic signed [PrioW-1:0] cprio  [DEPTH];

  // Handshakes
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Clamp capacity into 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(DEPTH)) begin
      cap_eff = CmpW'(DEPTH);
    end else begin
      cap_eff = CmpW'(cap_q);
    end
  end

  assign full  = CmpW'(count_q) >= cap_eff;
  assign empty = count_q == '0;

  // Decode the request into cell commands and the result
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_ENQ;
    value_d  = '0;
    if (!action_i) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        ctrl.enq = accept;
        status_d = ST_ENQ;
        count_d  = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        ctrl.deq = accept;
        status_d = ST_DEQ;
        value_d  = cval[0];
        count_d  = count_q - CntW'(1);
      end
    end
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_lt;
    logic signed [ValW-1:0]  left_val;
    logic signed [PrioW-1:0] left_prio;
    logic signed [ValW-1:0]  right_val;
    logic signed [PrioW-1:0] right_prio;
    logic                    occupied;

    assign occupied = CntW'(i) < count_q;

    if (i == 0) begin : g_head
      assign left_lt   = 1'b0;
      assign left_val  = cval[0];
      assign left_prio = cprio[0];
    end else begin : g_mid
      assign left_lt   = lt[i-1];
      assign left_val  = cval[i-1];
      assign left_prio = cprio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val  = cval[i];
      assign right_prio = cprio[i];
    end else begin : g_body
      assign right_val  = cval[i+1];
      assign right_prio = cprio[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied),
      .new_value_i  (item_value_i),
      .new_prio_i   (item_priority_i),
      .left_lt_i    (left_lt),
      .left_value_i (left_val),
      .left_prio_i  (left_prio),
      .right_value_i(right_val),
      .right_prio_i (right_prio),
      .lt_o         (lt[i]),
      .value_o      (cval[i]),
      .prio_o       (cprio[i])
    );
  end

  // Control state: count, capacity, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CapW'(16);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      value_q     <= value_d;
      res_count_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_value_o   = value_q;
  assign entry_count_o = CapW'(res_count_q);

endmodule

// ----- verif/spq_tb_pkg.sv -----
// Request codes shared by the priority queue testbench top and its checker.
// Depends on nothing.
package spq_tb_pkg;

  // Action field of an input request
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Length of the long receiver hold-off, in cycles
  localparam int unsigned HOLD_CYCLES = 80;

endpackage

// ----- verif/spq_checker.sv -----
// Checker for the sorted priority queue: keeps a shadow queue, predicts each
// result and compares it with what the block returns. Depends on spq_pkg, spq_tb_pkg.
module spq_checker
  import spq_pkg::*;
  import spq_tb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    action_i,
  input  logic signed [ValW-1:0]  item_value_i,
  input  logic signed [PrioW-1:0] item_priority_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              status_i,
  input  logic signed [ValW-1:0]  out_value_i,
  input  logic [CapW-1:0]         entry_count_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CapW-1:0]         cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [ValW-1:0]  value;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] value;
    logic [CapW-1:0]        count;
  } outcome_t;

  // Shadow copy of the queue contents and its capacity register
  entry_t          shadow_slots [DEPTH];
  int unsigned     shadow_held;
  logic [CapW-1:0] shadow_cap;
  outcome_t        outcomes_due [$];
  int unsigned     fail_count = 0;

  // Apply one request to the shadow queue and return the result it causes
  function automatic outcome_t serve_request(input logic act,
                                             input logic signed [ValW-1:0] val,
                                             input logic signed [PrioW-1:0] prio);
    outcome_t    res;
    int unsigned limit;
    int unsigned pos;
    limit = shadow_cap;
    if (limit < 1) limit = 1;
    if (limit > DEPTH) limit = DEPTH;
    res.value = '0;
    if (act == ACT_ENQ) begin
      if (shadow_held >= limit) begin
        res.status = ST_FULL;
      end else begin
        // shift lower priorities back; equal ones stay ahead of the newcomer
        pos = shadow_held;
        while (pos > 0 && $signed(shadow_slots[pos-1].prio) < prio) begin
          shadow_slots[pos] = shadow_slots[pos-1];
          pos--;
        end
        shadow_slots[pos].value = val;
        shadow_slots[pos].prio  = prio;
        shadow_held++;
        res.status = ST_ENQ;
      end
    end else if (shadow_held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.value = shadow_slots[0].value;
      for (int unsigned i = 1; i < shadow_held; i++) shadow_slots[i-1] = shadow_slots[i];
      shadow_held--;
      res.status = ST_DEQ;
    end
    res.count = shadow_held[CapW-1:0];
    return res;
  endfunction

  // Compare results, predict accepted requests, then track capacity writes
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      shadow_held = 0;
      shadow_cap  = CapW'(DEPTH);
      outcomes_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] result with nothing expected: status %0d value %0d count %0d",
                     $time, status_i, out_value_i, entry_count_i);
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (status_i !== want.status || out_value_i !== want.value ||
              entry_count_i !== want.count) begin
            if (fail_count < 10)
              $display("[%0t] mismatch (want/got): status %0d/%0d value %0d/%0d count %0d/%0d",
                       $time, want.status, status_i, $signed(want.value), out_value_i,
                       want.count, entry_count_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        outcomes_due.push_back(serve_request(action_i, item_value_i, item_priority_i));
      if (cfg_valid_i && cfg_ready_i) shadow_cap = cfg_data_i;
    end
    fail_count_o = fail_count;
    due_count_o  = outcomes_due.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the sorted priority queue: drives requests, capacity
// writes and receiver stalls. Depends on spq_pkg, spq_tb_pkg, spq_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    action;
  logic signed [ValW-1:0]  item_value;
  logic signed [PrioW-1:0] item_priority;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic signed [ValW-1:0]  out_value;
  logic [CapW-1:0]         entry_count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CapW-1:0]         cfg_data;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  sorted_priority_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .item_value_i    (item_value),
    .item_priority_i (item_priority),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .out_value_o     (out_value),
    .entry_count_o   (entry_count),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  spq_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .item_value_i    (item_value),
    .item_priority_i (item_priority),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .out_value_i     (out_value),
    .entry_count_i   (entry_count),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side: a pending hold-off first, else at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one request, idling first at random; call and return at a falling edge
  task automatic send_req(input logic act, input logic signed [ValW-1:0] val,
                          input logic signed [PrioW-1:0] prio);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    item_value    <= val;
    item_priority <= prio;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write the capacity register; only called while the block is idle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random requests in bursts that lean towards filling or emptying the queue
  task automatic run_random(input int unsigned n);
    int unsigned             burst_left;
    int unsigned             enq_pct;
    int                      p;
    logic                    act;
    logic signed [ValW-1:0]  val;
    logic signed [PrioW-1:0] prio;
    burst_left = 0;
    enq_pct    = 50;
    for (int unsigned k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0:       enq_pct = 80;
          1:       enq_pct = 20;
          default: enq_pct = 55;
        endcase
      end
      burst_left--;
      act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      // narrow priorities give plenty of ties
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          p    = int'($urandom_range(8)) - 4;
          prio = p[PrioW-1:0];
        end
        6, 7:    prio = PrioW'($urandom);
        8:       prio = 16'sh7FFF;
        default: prio = 16'sh8000;
      endcase
      case ($urandom_range(7))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        default: val = $urandom;
      endcase
      send_req(act, val, prio);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    action        = ACT_ENQ;
    item_value    = '0;
    item_priority = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_gap_pct   = 28;
    recv_stall_pct = 68;

    // extremes, ties and emptying past the end
    send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    send_req(ACT_ENQ, 32'sh7FFF_FFFF, 16'sh7FFF);
    send_req(ACT_ENQ, 32'sh8000_0000, 16'sh8000);
    send_req(ACT_ENQ, 32'sd0, 16'sd0);
    send_req(ACT_ENQ, -32'sd1, -16'sd1);
    send_req(ACT_ENQ, 32'sd1, 16'sd5);
    send_req(ACT_ENQ, 32'sd2, 16'sd5);
    send_req(ACT_ENQ, 32'sd3, 16'sd5);
    send_req(ACT_ENQ, 32'sd4, 16'sh7FFF);
    repeat (9) send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    drain();

    // small capacity reached, then lowered below the held count
    write_capacity(5'd2);
    send_req(ACT_ENQ, 32'sd10, 16'sd1);
    send_req(ACT_ENQ, 32'sd11, 16'sd2);
    send_req(ACT_ENQ, 32'sd12, 16'sd3);
    drain();
    write_capacity(5'd1);
    send_req(ACT_ENQ, 32'sd13, 16'sd4);
    send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    send_req(ACT_ENQ, 32'sd14, 16'sd4);
    send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    drain();

    // zero capacity behaves as one
    write_capacity(5'd0);
    send_req(ACT_ENQ, 32'sd15, -16'sd7);
    send_req(ACT_ENQ, 32'sd16, 16'sd7);
    send_req(ACT_DEQ, $urandom, PrioW'($urandom));
    drain();

    // sender idles lightly, receiver heavily
    write_capacity(5'd31);
    run_random(260);
    drain();
    write_capacity(5'd16);
    run_random(270);
    drain();

    // sender idles heavily, receiver lightly
    send_gap_pct   = 68;
    recv_stall_pct = 28;
    write_capacity(5'd7);
    run_random(265);
    drain();
    write_capacity(5'd3);
    run_random(265);
    drain();

    // no idling, with a long receiver hold-off to back the block up
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_capacity(5'd1);
    run_random(200);
    drain();
    write_capacity(5'd17);
    hold_left = HOLD_CYCLES;
    run_random(330);
    drain();

    repeat (5) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
